@@ rtl/pal_pkg.sv @@
// shared types and constants of the positional array list
`default_nettype none

package pal_pkg;

  // fixed field widths
  localparam int WORD_W  = 32;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 2;

  // default list depth
  localparam int CAPACITY_DEF = 64;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // latch a new request beat
    logic rd_pos;   // read the entry at the target position
    logic capture;  // keep the word just read as the result
    logic shift;    // move one entry one place
    logic finish;   // commit the length and issue the result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ins_ok;
    logic del_ok;
    logic rd_ok;
    logic no_move;     // no entry needs to move
    logic shift_last;  // current move is the final one
  } status_t;

endpackage

`default_nettype wire

@@ rtl/pal_ctrl.sv @@
// controller state machine of the positional array list
`default_nettype none

module pal_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire pal_pkg::status_t status,
  output pal_pkg::cmd_t         cmd,
  output logic                  busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_SHIFT,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status.rd_ok || status.del_ok) begin
          cmd.rd_pos = 1'b1;
          state_next = ST_FETCH;
        end else if (status.ins_ok && !status.no_move) begin
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FETCH: begin
        cmd.capture = 1'b1;
        if (status.rd_ok || status.no_move) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.shift_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  // busy tracks the state register
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE))
    else $error("busy out of step with state");

  // an accepted beat goes straight to the check
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_CHECK))
    else $error("accepted beat not checked");

  // the final move is followed by the drain cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && status.shift_last) |=> (state == ST_DRAIN))
    else $error("shift did not end in drain");

endmodule

`default_nettype wire

@@ rtl/pal_dpath.sv @@
// datapath of the positional array list: entry memory, length, move pipeline
`default_nettype none

module pal_dpath #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pal_pkg::cmd_t                       cmd,
  input  wire logic [pal_pkg::KIND_W-1:0]          kind,
  input  wire logic [pal_pkg::POS_W-1:0]           position,
  input  wire logic signed [pal_pkg::WORD_W-1:0]   value_in,
  output pal_pkg::status_t                         status,
  output logic                                     done,
  output logic                                     ok,
  output logic signed [pal_pkg::WORD_W-1:0]        value_out,
  output logic [pal_pkg::COUNT_W-1:0]              count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > pal_pkg::POS_W) ? LW : pal_pkg::POS_W) + 1;

  // entry storage
  logic [pal_pkg::WORD_W-1:0] mem [CAPACITY];
  logic [pal_pkg::WORD_W-1:0] rdata;

  // latched request and working registers
  logic [pal_pkg::KIND_W-1:0] kind_q;
  logic [pal_pkg::POS_W-1:0]  pos_q;
  logic [pal_pkg::WORD_W-1:0] word_q;
  logic [pal_pkg::WORD_W-1:0] res;
  logic [LW-1:0]              len;
  logic [AW-1:0]              ptr;
  logic                       mv_v;
  logic [AW-1:0]              mv_dst;

  logic [CW-1:0] pos_w;
  logic [CW-1:0] len_w;
  logic          sel_ok;
  logic          is_ins;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] raddr;
  logic          rd_en;
  logic [LW-1:0] len_after;

  // position checks and addresses
  always_comb begin
    pos_w     = CW'(pos_q);
    len_w     = CW'(len);
    is_ins    = (kind_q == pal_pkg::KIND_INSERT);
    sel_ok    = (pos_w != '0) && (pos_w <= len_w);
    pos_idx   = AW'(pos_w - CW'(1));
    status.ins_ok  = is_ins && (pos_w != '0) && (pos_w <= len_w + CW'(1))
                     && (len_w < CW'(CAPACITY));
    status.del_ok  = (kind_q == pal_pkg::KIND_DELETE) && sel_ok;
    status.rd_ok   = (kind_q == pal_pkg::KIND_READ) && sel_ok;
    status.no_move = is_ins ? (pos_w == len_w + CW'(1)) : (pos_w == len_w);
    status.shift_last = is_ins ? (ptr == pos_idx) : (ptr == AW'(len_w - CW'(1)));
    raddr     = cmd.rd_pos ? pos_idx : ptr;
    rd_en     = cmd.rd_pos || cmd.shift;
    priority if (status.ins_ok) begin
      len_after = len + LW'(1);
    end else if (status.del_ok) begin
      len_after = len - LW'(1);
    end else begin
      len_after = len;
    end
  end

  // memory: one read port with registered data, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (mv_v) begin
      mem[mv_dst] <= rdata;
    end else if (cmd.finish && status.ins_ok) begin
      mem[pos_idx] <= word_q;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      mv_v <= 1'b0;
      done <= 1'b0;
    end else begin
      mv_v <= cmd.shift;
      done <= cmd.finish;
      if (cmd.finish) begin
        len <= len_after;
      end
    end
  end

  // request, move pointer and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      pos_q  <= position;
      word_q <= value_in;
      // insert walks down from the top entry, delete walks up past the target
      ptr    <= (kind == pal_pkg::KIND_INSERT) ? AW'(len - LW'(1)) : AW'(position);
    end
    if (cmd.shift) begin
      ptr    <= is_ins ? (ptr - AW'(1)) : (ptr + AW'(1));
      mv_dst <= is_ins ? (ptr + AW'(1)) : (ptr - AW'(1));
    end
    if (cmd.capture) begin
      res <= rdata;
    end
    if (cmd.finish) begin
      ok        <= status.ins_ok || status.del_ok || status.rd_ok;
      value_out <= (status.del_ok || status.rd_ok) ? res : '0;
      count     <= pal_pkg::COUNT_W'(len_after);
    end
  end

  // a pending move write never meets the insert write
  a_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(mv_v && cmd.finish))
    else $error("move write collides with final write");

  // length stays within capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(CAPACITY))
    else $error("length above capacity");

  // a result beat follows a finish command
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.finish))
    else $error("result strobe without finish");

endmodule

`default_nettype wire

@@ rtl/positional_array_list_core.sv @@
// top level of the positional array list: controller plus datapath
//
//   channel   signals                           handshake
//   request   kind, position, value_in          start, taken when busy is low
//   result    ok, value_out, count              done, one cycle, no backpressure
//
// done rises after check, fetch and finish for a read or a delete of the last entry,
// after check and finish for a refused request or a tail insert; an insert moving
// k entries (k up to CAPACITY-1) adds k shift states and a drain state after check,
// a delete after fetch, one move per cycle through the single read and write port.
// Reset empties the list at once; stored words are not cleared.
// busy drops in the cycle of the done strobe; the receiver cannot stall the beat.
`default_nettype none

module positional_array_list_core #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [pal_pkg::KIND_W-1:0]          kind,
  input  wire logic [pal_pkg::POS_W-1:0]           position,
  input  wire logic signed [pal_pkg::WORD_W-1:0]   value_in,
  output logic                                     done,
  output logic                                     ok,
  output logic signed [pal_pkg::WORD_W-1:0]        value_out,
  output logic [pal_pkg::COUNT_W-1:0]              count
);

  pal_pkg::cmd_t    cmd;
  pal_pkg::status_t status;

  // sequencer
  pal_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // storage and result path
  pal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (kind),
    .position  (position),
    .value_in  (value_in),
    .status    (status),
    .done      (done),
    .ok        (ok),
    .value_out (value_out),
    .count     (count)
  );

endmodule

`default_nettype wire

@@ bench/tb_positional_array_list_core.sv @@
// testbench for the positional array list core: directed table, then random phases checked by a predictor
`default_nettype none

module tb_positional_array_list_core;
  import pal_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int REQUEST_TARGET = 1750;
  // stall limit lies well above the slowest beat and the longest sender gap
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = LIST_DEPTH + 16;
  localparam int DIRECTED_N = 20;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  typedef struct packed {
    logic                      ok;
    logic signed [WORD_W-1:0]  word;
    logic [COUNT_W-1:0]        count;
  } reply_t;

  typedef struct {
    logic [KIND_W-1:0]         op;
    logic [POS_W-1:0]          pos;
    logic signed [WORD_W-1:0]  word;
    logic                      typed;
    reply_t                    reply;
  } stim_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [KIND_W-1:0]         kind;
  logic [POS_W-1:0]          position;
  logic signed [WORD_W-1:0]  value_in;
  logic                      done;
  logic                      ok;
  logic signed [WORD_W-1:0]  value_out;
  logic [COUNT_W-1:0]        count;

  // predictor state: a copy of the list
  logic signed [WORD_W-1:0]  list_words [LIST_DEPTH];
  int                        list_len;

  reply_t                    expected_replies [$];
  reply_t                    want_reply;
  int                        mismatches;
  int                        requests_sent;
  int                        stall_cycles;
  logic                      idle_on;

  // directed table, typed replies where they are obvious
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{KIND_READ,   7'd1,   32'sd5,           1'b1, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_DELETE, 7'd1,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd0,   32'sd9,           1'b1, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd2,   32'sd9,           1'b1, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd1,   32'sh7FFF_FFFF,   1'b1, '{1'b1, 32'sd0, 7'd1}},
    '{KIND_INSERT, 7'd1,   32'sh8000_0000,   1'b1, '{1'b1, 32'sd0, 7'd2}},
    '{KIND_INSERT, 7'd3,   32'shFFFF_FFFF,   1'b1, '{1'b1, 32'sd0, 7'd3}},
    '{KIND_READ,   7'd1,   32'sd0,           1'b1, '{1'b1, 32'sh8000_0000, 7'd3}},
    '{KIND_READ,   7'd3,   32'sd0,           1'b1, '{1'b1, 32'shFFFF_FFFF, 7'd3}},
    '{KIND_READ,   7'd4,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd3}},
    '{KIND_UNUSED, 7'd1,   32'sh1234_5678,   1'b1, '{1'b0, 32'sd0, 7'd3}},
    '{KIND_READ,   7'd127, 32'shFFFF_FFFF,   1'b1, '{1'b0, 32'sd0, 7'd3}},
    '{KIND_INSERT, 7'd127, 32'sh0F0F_0F0F,   1'b1, '{1'b0, 32'sd0, 7'd3}},
    '{KIND_DELETE, 7'd2,   32'sd0,           1'b1, '{1'b1, 32'sh7FFF_FFFF, 7'd2}},
    '{KIND_DELETE, 7'd0,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd2}},
    '{KIND_INSERT, 7'd2,   32'sd0,           1'b0, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd4,   32'sh5A5A_A5A5,   1'b0, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_DELETE, 7'd4,   32'sd0,           1'b0, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_READ,   7'd2,   32'sd0,           1'b0, '{1'b0, 32'sd0, 7'd0}},
    '{KIND_DELETE, 7'd1,   32'sd0,           1'b0, '{1'b0, 32'sd0, 7'd0}}
  };

  positional_array_list_core #(.CAPACITY(LIST_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .position  (position),
    .value_in  (value_in),
    .done      (done),
    .ok        (ok),
    .value_out (value_out),
    .count     (count)
  );

  // clock, period 12
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one request to the list copy and return the reply it gives
  function automatic reply_t apply_request(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic signed [WORD_W-1:0] word);
    reply_t r;
    int     p;
    int     j;
    r = '{1'b0, 32'sd0, 7'd0};
    p = int'(pos);
    case (op)
      KIND_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
          for (j = list_len; j > p - 1; j--)
            list_words[j] = list_words[j-1];
          list_words[p-1] = word;
          list_len++;
          r.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          r.word = list_words[p-1];
          for (j = p; j < list_len; j++)
            list_words[j-1] = list_words[j];
          list_len--;
          r.ok = 1'b1;
        end
      end
      KIND_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.word = list_words[p-1];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // present one request beat from a falling edge and hold it until taken
  task automatic send_request(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [WORD_W-1:0] word, input logic typed,
                              input reply_t typed_reply);
    reply_t predicted;
    int     gap;
    kind     <= op;
    position <= pos;
    value_in <= word;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_request(op, pos, word);
    expected_replies.push_back(typed ? typed_reply : predicted);
    requests_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold off the sender until every reply is in
  task automatic drain_replies();
    start <= 1'b0;
    do @(negedge clk); while (expected_replies.size() != 0);
  endtask

  // one random request, mostly valid positions for the current length
  task automatic send_random(input phase_e phase);
    int                  roll;
    logic [KIND_W-1:0]   op;
    int                  pos;
    roll = $urandom_range(0, 99);
    if (phase == PH_FILL) begin
      op  = KIND_INSERT;
      pos = (list_len < LIST_DEPTH) ? $urandom_range(1, list_len + 1) : $urandom_range(0, 127);
    end else if (phase == PH_DRAIN) begin
      op  = (roll < 85) ? KIND_DELETE : KIND_READ;
      pos = (list_len > 0) ? $urandom_range(1, list_len) : $urandom_range(0, 127);
    end else if (roll < 30) begin
      op  = KIND_INSERT;
      pos = $urandom_range(1, list_len + 1);
    end else if (roll < 80) begin
      op  = (roll < 55) ? KIND_DELETE : KIND_READ;
      pos = (list_len > 0) ? $urandom_range(1, list_len) : $urandom_range(0, 2);
    end else begin
      // noise: any kind, positions around the edges or anywhere
      op = KIND_W'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       pos = 0;
        1:       pos = list_len;
        2:       pos = list_len + 1;
        3:       pos = list_len + 2;
        default: pos = $urandom_range(0, 127);
      endcase
    end
    send_request(op, POS_W'(pos), $urandom, 1'b0, '{1'b0, 32'sd0, 7'd0});
  endtask

  // stimulus
  initial begin
    int     i;
    int     n;
    phase_e phase;
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_INSERT;
    position    = '0;
    value_in    = '0;
    list_len    = 0;
    mismatches  = 0;
    requests_sent = 0;
    idle_on     = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIRECTED_N; i++)
      send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].word,
                   directed_rows[i].typed, directed_rows[i].reply);
    drain_replies();

    // random phases: fill to full, drain to empty, or mixed traffic
    while (requests_sent < REQUEST_TARGET + DIRECTED_N) begin
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(0, 9);
      phase = (n < 2) ? PH_FILL : (n < 4) ? PH_DRAIN : PH_MIXED;
      if (phase == PH_FILL) begin
        while (list_len < LIST_DEPTH) send_random(PH_FILL);
        repeat ($urandom_range(1, 3)) send_random(PH_FILL);
      end else if (phase == PH_DRAIN) begin
        while (list_len > 0) send_random(PH_DRAIN);
        repeat ($urandom_range(1, 3)) send_random(PH_DRAIN);
      end else begin
        repeat ($urandom_range(20, 60)) send_random(PH_MIXED);
      end
      if ($urandom_range(0, 9) == 0) drain_replies();
    end

    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // compare each result beat with the oldest expected reply
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got ok=%0d value=%0d count=%0d",
                 $time, ok, value_out, count);
        mismatches++;
      end else begin
        want_reply = expected_replies.pop_front();
        if (ok !== want_reply.ok) begin
          $display("%0t: ok mismatch, expected %0d, got %0d", $time, want_reply.ok, ok);
          mismatches++;
        end
        if (value_out !== want_reply.word) begin
          $display("%0t: value_out mismatch, expected %0d, got %0d",
                   $time, want_reply.word, value_out);
          mismatches++;
        end
        if (count !== want_reply.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d",
                   $time, want_reply.count, count);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat taken on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

`default_nettype wire
